// ----- rtl/core/rme_pkg.sv -----
// ----------------------------------------------------------------------------
// rme_pkg: shared definitions for the RSA modular exponentiation block
// Register indexes, reset values, default sizes and the control structs
// that pass between the sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int MOD_BITS_DEF = 32;
  localparam int EXP_BITS_DEF = 16;

  // Widths of the configuration registers and of the result field.
  localparam int MODULUS_W  = 32;
  localparam int EXPONENT_W = 16;
  localparam int CIPHER_W   = 32;
  localparam int MESSAGE_W  = 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [MODULUS_W-1:0]  MODULUS_RST  = 32'd33;
  localparam logic [EXPONENT_W-1:0] EXPONENT_RST = 16'd7;

  typedef struct packed {
    logic start;
  } mm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_rsp_t;

endpackage

// ----- rtl/core/rme_modmul.sv -----
// ----------------------------------------------------------------------------
// rme_modmul: bit-serial modular multiplier
// Computes a * b mod n by shift-and-add, one bit of b at a time, top bit first: a
// doubling step and a conditional add step, each reduced modulo n.
// ----------------------------------------------------------------------------
module rme_modmul #(
  parameter int W = rme_pkg::MOD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rme_pkg::mm_req_t req,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  input  logic [W-1:0]     n,
  output rme_pkg::mm_rsp_t rsp,
  output logic [W-1:0]     p
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          phase_r, phase_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;

  logic [W-1:0]  opnd;
  logic [W:0]    sum;
  logic [W+1:0]  diff;
  logic [W-1:0]  red;

  // One shared add-and-reduce: both operands are already below n.
  assign opnd = phase_r ? a_r : acc_r;
  assign sum  = {1'b0, acc_r} + {1'b0, opnd};
  assign diff = {1'b0, sum} - {2'b00, n};
  assign red  = diff[W+1] ? sum[W-1:0] : diff[W-1:0];

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      cnt_nxt   = CW'(W);
      acc_nxt   = '0;
      a_nxt     = a;
      b_nxt     = b;
    end else if (busy_r) begin
      if (!phase_r) begin
        acc_nxt   = red;
        phase_nxt = 1'b1;
      end else begin
        if (b_r[W-1]) begin
          acc_nxt = red;
        end
        b_nxt     = {b_r[W-2:0], 1'b0};
        phase_nxt = 1'b0;
        cnt_nxt   = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign p        = acc_r;

endmodule

// ----- rtl/core/rsa_modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation_top: byte-wide RSA modular exponentiation
// Raises each message byte to the configured exponent modulo the configured
// modulus by left-to-right square-and-multiply over a bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_ready  | in_message_byte[7:0]
//  out_     | output    | out_valid/out_ready| out_cipher_value[31:0]
//  cfg_     | input     | cfg_we (no wait)   | cfg_index[0], cfg_wdata[31:0]
//
// One item is worked on at a time. Each modular multiply runs in rme_modmul
// on NW bits, NW being the used modulus width (32 by default). An item
// takes 1 + EXP_BITS + ones(e) multiplies; an exponent of 0 or 1 takes
// one multiply, and a modulus of 0 or 1 takes none and gives 0. Reset is
// synchronous and active low and loads the registers with modulus 33 and
// exponent 7. A finished item waits in the output register while the next
// item is accepted; the sequencer stalls only if a second result is ready
// before the first has been taken.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation_top #(
  parameter int MOD_BITS = rme_pkg::MOD_BITS_DEF,
  parameter int EXP_BITS = rme_pkg::EXP_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rme_pkg::MESSAGE_W-1:0]   in_message_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rme_pkg::CIPHER_W-1:0]    out_cipher_value,
  input  logic                            cfg_we,
  input  logic [rme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rme_pkg::MODULUS_W-1:0]   cfg_wdata
);

  // The modulus register is 32 bits, so no residue is ever wider than that.
  localparam int NW = (MOD_BITS < rme_pkg::MODULUS_W) ? MOD_BITS : rme_pkg::MODULUS_W;
  localparam int IW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BASE = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rme_pkg::MODULUS_W-1:0]   modulus_r;
  logic [rme_pkg::EXPONENT_W-1:0]  exponent_r;
  logic [NW-1:0]                   n_r, n_nxt;
  logic [EXP_BITS-1:0]             e_r, e_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [NW-1:0]                   base_r, base_nxt;
  logic [NW-1:0]                   res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rme_pkg::CIPHER_W-1:0]    out_cipher_r, out_cipher_nxt;

  logic [63:0]                     mod_ext;
  logic [47:0]                     exp_ext;
  logic [NW-1:0]                   n_cfg;
  logic [EXP_BITS-1:0]             e_cfg;

  rme_pkg::mm_req_t                mm_req;
  rme_pkg::mm_rsp_t                mm_rsp;
  logic [NW-1:0]                   mm_a;
  logic [NW-1:0]                   mm_b;
  logic [NW-1:0]                   mm_p;

  assign mod_ext = {32'd0, modulus_r};
  assign exp_ext = {32'd0, exponent_r};
  assign n_cfg   = mod_ext[NW-1:0];
  assign e_cfg   = exp_ext[EXP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= rme_pkg::MODULUS_RST;
      exponent_r <= rme_pkg::EXPONENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rme_pkg::REG_MODULUS:  modulus_r  <= cfg_wdata;
        rme_pkg::REG_EXPONENT: exponent_r <= cfg_wdata[rme_pkg::EXPONENT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    e_nxt          = e_r;
    idx_nxt        = idx_r;
    base_nxt       = base_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_cipher_nxt = out_cipher_r;
    mm_req.start   = 1'b0;
    mm_a           = mm_p;
    mm_b           = mm_p;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt = n_cfg;
          e_nxt = e_cfg;
          if (n_cfg <= NW'(1)) begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // The message is reduced as 1 * m mod n on the multiplier.
            mm_req.start = 1'b1;
            mm_a         = NW'(1);
            mm_b         = NW'(in_message_byte);
            state_nxt    = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        if (mm_rsp.done) begin
          base_nxt = mm_p;
          if (e_r <= EXP_BITS'(1)) begin
            res_nxt   = mm_p;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt      = IW'(EXP_BITS - 1);
            mm_req.start = 1'b1;
            mm_a         = NW'(1);
            mm_b         = NW'(1);
            state_nxt    = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          if (e_r[idx_r]) begin
            mm_req.start = 1'b1;
            mm_b         = base_r;
            state_nxt    = ST_MUL;
          end else if (idx_r == '0) begin
            res_nxt   = mm_p;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt      = idx_r - IW'(1);
            mm_req.start = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          if (idx_r == '0) begin
            res_nxt   = mm_p;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt      = idx_r - IW'(1);
            mm_req.start = 1'b1;
            state_nxt    = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_cipher_nxt = rme_pkg::CIPHER_W'(res_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    e_r          <= e_nxt;
    base_r       <= base_nxt;
    res_r        <= res_nxt;
    out_cipher_r <= out_cipher_nxt;
  end

  rme_modmul #(
    .W (NW)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .a     (mm_a),
    .b     (mm_b),
    .n     (n_r),
    .rsp   (mm_rsp),
    .p     (mm_p)
  );

  assign out_valid        = out_valid_r;
  assign out_cipher_value = out_cipher_r;

  // An accepted item either starts the base reduction or finishes at once.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == ST_BASE || state_r == ST_DONE))
    else $error("accepted item did not start work");

  // The multiplier is never restarted while it is still running.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier restarted while busy");

  // A new result is loaded only from the finishing state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a finished item");

  // A finished residue is always below the modulus, or zero.
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> (res_r < n_r || res_r == '0))
    else $error("residue not reduced");

endmodule
